// ===== src/kpa_pkg.sv =====
// ----------------------------------------------------------------------------
// kpa_pkg: shared types and constants for the keypad register block
// Button codes, key bit positions of the eight autofire slots, and the
// word and result types passed between the modules.
// ----------------------------------------------------------------------------
package kpa_pkg;

    localparam int NUM_SLOTS = 8;

    // Button codes of the input word
    localparam logic [3:0] BTN_A     = 4'd0;
    localparam logic [3:0] BTN_B     = 4'd1;
    localparam logic [3:0] BTN_C     = 4'd2;
    localparam logic [3:0] BTN_POWER = 4'd3;
    localparam logic [3:0] BTN_LEFT  = 4'd4;
    localparam logic [3:0] BTN_RIGHT = 4'd5;
    localparam logic [3:0] BTN_UP    = 4'd6;
    localparam logic [3:0] BTN_DOWN  = 4'd7;
    localparam logic [3:0] BTN_SHOCK = 4'd8;

    // Source codes
    localparam logic MODE_KEYBOARD = 1'b0;
    localparam logic MODE_JOYSTICK = 1'b1;

    // Key register bit for each slot, slots in button order
    localparam logic [2:0] SLOT_BIT [NUM_SLOTS] = '{
        3'd0, 3'd1, 3'd2, 3'd7, 3'd5, 3'd6, 3'd3, 3'd4
    };

    // Key register mask for each slot
    localparam logic [7:0] SLOT_MASK [NUM_SLOTS] = '{
        8'h01, 8'h02, 8'h04, 8'h80, 8'h20, 8'h40, 8'h08, 8'h10
    };

    typedef logic [NUM_SLOTS-1:0][7:0] delay_arr_t;

    typedef struct packed {
        logic       mode;
        logic [3:0] button;
        logic       pressed;
    } kpa_item_t;

    typedef struct packed {
        logic [7:0] key_state;
        logic       shock_request;
    } kpa_result_t;

endpackage

// ===== src/kpa_in_if.sv =====
// ----------------------------------------------------------------------------
// kpa_in_if: button change channel
// Valid/ready channel carrying one button change word.
// ----------------------------------------------------------------------------
interface kpa_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [3:0] button;
    logic       pressed;

    modport source (output valid, output mode, output button, output pressed,
                    input ready);
    modport sink   (input valid, input mode, input button, input pressed,
                    output ready);
endinterface

// ===== src/kpa_out_if.sv =====
// ----------------------------------------------------------------------------
// kpa_out_if: key state channel
// Valid/ready channel carrying the key register and the shock pulse.
// ----------------------------------------------------------------------------
interface kpa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_state;
    logic       shock_request;

    modport source (output valid, output key_state, output shock_request,
                    input ready);
    modport sink   (input valid, input key_state, input shock_request,
                    output ready);
endinterface

// ===== src/keypad_register_with_autofire.sv =====
// A word accepted on button_ch passes through the input register, then the
// result register, from which key_ch presents its result.
// Throughput: one word per cycle while key_ch takes results; the single-pass
// update of the key register and all eight autofire slots sets this.
// Reset: asynchronous, active low; keys all released, direction memory,
// autofire slots and turbo delays cleared; no clearing pass.
// ----------------------------------------------------------------------------
// keypad_register_with_autofire: top level
// Input register, state engine, result register and turbo delay registers.
// ----------------------------------------------------------------------------
module keypad_register_with_autofire
    import kpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    kpa_in_if.sink     button_ch,
    kpa_out_if.source  key_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic        in_valid_reg;
    kpa_item_t   in_item_reg;
    logic        out_valid_reg;
    kpa_result_t out_data_reg;

    logic        advance;
    logic        step_en;
    delay_arr_t  delays;
    kpa_result_t result;
    kpa_item_t   in_word;

    assign advance = !out_valid_reg || key_ch.ready;
    assign step_en = in_valid_reg && advance;
    assign button_ch.ready = !in_valid_reg || advance;

    assign in_word.mode    = button_ch.mode;
    assign in_word.button  = button_ch.button;
    assign in_word.pressed = button_ch.pressed;

    kpa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .delays    (delays)
    );

    kpa_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_item_reg),
        .delays  (delays),
        .result  (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (button_ch.valid && button_ch.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (button_ch.valid && button_ch.ready)
        begin
            in_item_reg <= in_word;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            out_data_reg <= result;
        end
    end

    assign key_ch.valid         = out_valid_reg;
    assign key_ch.key_state     = out_data_reg.key_state;
    assign key_ch.shock_request = out_data_reg.shock_request;

`ifndef SYNTH
    // a pending word moves to an empty result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word stuck in input register");

    // a taken result with nothing behind it empties the output
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && key_ch.ready && !in_valid_reg |=> !out_valid_reg)
        else $error("result repeated");

    // shock pulse follows the word that pressed the shock button
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_data_reg.shock_request ==
            (($past(in_item_reg.button) == BTN_SHOCK) && $past(in_item_reg.pressed)))
        else $error("shock pulse mismatch");
`endif

endmodule

// ===== src/kpa_cfg.sv =====
// ----------------------------------------------------------------------------
// kpa_cfg: turbo delay registers
// Eight 8-bit autofire periods written through a plain write port.
// ----------------------------------------------------------------------------
module kpa_cfg
    import kpa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output delay_arr_t delays
);

    delay_arr_t delay_reg;

    // register file, one write per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            delay_reg[cfg_index] <= cfg_data;
        end
    end

    assign delays = delay_reg;

endmodule

// ===== src/kpa_engine.sv =====
// ----------------------------------------------------------------------------
// kpa_engine: key register, direction memory and autofire slots
// Holds the block state and computes one word's result in a single pass;
// the state advances when step_en is high.
// ----------------------------------------------------------------------------
module kpa_engine
    import kpa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  kpa_item_t   item,
    input  delay_arr_t  delays,
    output kpa_result_t result
);

    logic [7:0]                 key_bits_reg, key_bits_next;
    logic [3:0]                 held_reg, held_next;
    logic [NUM_SLOTS-1:0]       active_reg, active_next;
    logic [NUM_SLOTS-1:0][7:0]  count_reg, count_next;

    logic [7:0] kb_dir;
    logic       enabled;

    assign enabled = |delays;

    // button event: plain keys, directions with opposite handling
    always_comb
    begin
        logic [7:0] own_mask;
        logic [7:0] opp_mask;
        logic [1:0] own_h;
        logic [1:0] opp_h;
        logic [3:0] hd;
        own_mask = SLOT_MASK[item.button[2:0]];
        opp_mask = SLOT_MASK[item.button[2:0] ^ 3'd1];
        own_h    = item.button[1:0];
        opp_h    = item.button[1:0] ^ 2'd1;
        hd       = held_reg;
        kb_dir   = key_bits_reg;
        if (item.button[3:2] == 2'b00)
        begin
            kb_dir = item.pressed ? (key_bits_reg & ~own_mask)
                                  : (key_bits_reg | own_mask);
        end
        else if (item.button[3:2] == 2'b01)
        begin
            if (item.pressed)
            begin
                kb_dir = (key_bits_reg & ~own_mask) | opp_mask;
                if (item.mode == MODE_KEYBOARD)
                    hd[own_h] = 1'b1;
            end
            else
            begin
                kb_dir = key_bits_reg | own_mask;
                if (item.mode == MODE_KEYBOARD)
                begin
                    hd[own_h] = 1'b0;
                    kb_dir = hd[opp_h] ? (kb_dir & ~opp_mask) : (kb_dir | opp_mask);
                end
                else
                begin
                    kb_dir = kb_dir | opp_mask;
                end
            end
        end
        held_next = hd;
    end

    // autofire pass, slots are independent and each owns one key bit
    always_comb
    begin
        logic       key_bit;
        logic       act;
        logic [7:0] cnt;
        key_bits_next = kb_dir;
        active_next   = active_reg;
        count_next    = count_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            key_bit = kb_dir[SLOT_BIT[i]];
            act     = active_reg[i];
            cnt     = count_reg[i];
            if (enabled)
            begin
                if (!key_bit && (delays[i] != 8'd0) && !act)
                begin
                    act     = 1'b1;
                    cnt     = 8'd0;
                    key_bit = 1'b1;
                end
                else if (act)
                begin
                    if (cnt != 8'hFF)
                        cnt = cnt + 8'd1;
                    if (cnt >= delays[i])
                    begin
                        act     = 1'b0;
                        key_bit = 1'b0;
                    end
                end
                if ((item.button == 4'(i)) && !item.pressed)
                begin
                    act     = 1'b0;
                    cnt     = 8'd0;
                    key_bit = 1'b1;
                end
            end
            key_bits_next[SLOT_BIT[i]] = key_bit;
            active_next[i]             = act;
            count_next[i]              = cnt;
        end
    end

    assign result.key_state     = key_bits_next;
    assign result.shock_request = (item.button == BTN_SHOCK) && item.pressed;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bits_reg <= 8'hFF;
            held_reg     <= '0;
            active_reg   <= '0;
            count_reg    <= '0;
        end
        else if (step_en)
        begin
            key_bits_reg <= key_bits_next;
            held_reg     <= held_next;
            active_reg   <= active_next;
            count_reg    <= count_next;
        end
    end

`ifndef SYNTH
    // joystick words leave the direction memory alone
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.mode == MODE_JOYSTICK) |=> $stable(held_reg))
        else $error("direction memory changed on joystick word");

    // with every delay at zero the slots do not move
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && !enabled |=> $stable(active_reg) && $stable(count_reg))
        else $error("autofire slot moved while disabled");

    // releasing A with autofire on leaves its slot idle and the key up
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && enabled && (item.button == BTN_A) && !item.pressed
        |=> !active_reg[0] && key_bits_reg[SLOT_BIT[0]])
        else $error("slot A still firing after release");
`endif

endmodule

// ===== tb/tb_keypad_register_with_autofire.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_register_with_autofire: self-checking testbench
// Drives button change words into the keypad register and predicts the key
// state and shock pulse of each word. The prediction covers opposite-direction
// handling, keyboard direction memory and the per-slot autofire pass. Both
// channels idle at random, and the turbo delays are changed between phases.
// ----------------------------------------------------------------------------
module tb_keypad_register_with_autofire;
    import kpa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int LONG_HOLD   = 80;

    // Expected key state, kept in step with every accepted button word
    class key_state_board;
        logic [7:0]  delay [NUM_SLOTS];
        logic [7:0]  keys;
        logic [3:0]  held;
        bit          active [NUM_SLOTS];
        logic [7:0]  count [NUM_SLOTS];
        kpa_result_t key_q [$];
        int          fail_count;

        function new();
            keys = 8'hFF;
            held = 4'h0;
            fail_count = 0;
            foreach (delay[i])
            begin
                delay[i]  = 8'h00;
                active[i] = 1'b0;
                count[i]  = 8'h00;
            end
        endfunction

        function void set_delay(int idx, logic [7:0] val);
            delay[idx] = val;
        endfunction

        function int pending();
            return key_q.size();
        endfunction

        // Direction press or release; left/right and up/down pair on bit 0
        function void move_direction(logic [3:0] btn, bit keyboard, bit press);
            int         own_slot;
            int         opp_slot;
            logic [7:0] own;
            logic [7:0] opp;
            own_slot = int'(btn);
            opp_slot = own_slot ^ 1;
            own = SLOT_MASK[own_slot];
            opp = SLOT_MASK[opp_slot];
            if (press)
            begin
                keys = (keys & ~own) | opp;
                if (keyboard)
                    held[own_slot - int'(BTN_LEFT)] = 1'b1;
            end
            else
            begin
                keys = keys | own;
                if (keyboard)
                begin
                    held[own_slot - int'(BTN_LEFT)] = 1'b0;
                    // opposite still held on the keyboard comes back
                    if (held[opp_slot - int'(BTN_LEFT)])
                        keys = keys & ~opp;
                    else
                        keys = keys | opp;
                end
                else
                    keys = keys | opp;
            end
        endfunction

        function void note_word(kpa_item_t w);
            bit          keyboard;
            bit          turbo_on;
            bit          shock;
            logic [7:0]  m;
            kpa_result_t r;
            keyboard = (w.mode == MODE_KEYBOARD);
            shock    = 1'b0;
            turbo_on = 1'b0;

            // button change
            if (w.button <= BTN_POWER)
            begin
                if (w.pressed)
                    keys = keys & ~SLOT_MASK[w.button[2:0]];
                else
                    keys = keys | SLOT_MASK[w.button[2:0]];
            end
            else if (w.button >= BTN_LEFT && w.button <= BTN_DOWN)
                move_direction(w.button, keyboard, w.pressed);
            else if (w.button == BTN_SHOCK && w.pressed)
                shock = 1'b1;

            foreach (delay[i])
                if (delay[i] != 8'h00)
                    turbo_on = 1'b1;

            // autofire pass over all slots
            if (turbo_on)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    m = SLOT_MASK[i];
                    if ((keys & m) == 8'h00 && delay[i] != 8'h00 && !active[i])
                    begin
                        active[i] = 1'b1;
                        count[i]  = 8'h00;
                        keys      = keys | m;
                    end
                    else if (active[i])
                    begin
                        if (count[i] != 8'hFF)
                            count[i] = count[i] + 8'h01;
                        if (count[i] >= delay[i])
                        begin
                            active[i] = 1'b0;
                            keys      = keys & ~m;
                        end
                    end
                    if (int'(w.button) == i && !w.pressed)
                    begin
                        active[i] = 1'b0;
                        count[i]  = 8'h00;
                        keys      = keys | m;
                    end
                end
            end

            r.key_state     = keys;
            r.shock_request = shock;
            key_q.push_back(r);
        endfunction

        function void check_word(kpa_result_t got);
            kpa_result_t want;
            if (key_q.size() == 0)
            begin
                $error("key word with nothing expected: key_state %h shock_request %b",
                       got.key_state, got.shock_request);
                fail_count++;
                return;
            end
            want = key_q.pop_front();
            if (got.key_state !== want.key_state)
            begin
                $error("key_state: expected %h, got %h", want.key_state, got.key_state);
                fail_count++;
            end
            if (got.shock_request !== want.shock_request)
            begin
                $error("shock_request: expected %b, got %b",
                       want.shock_request, got.shock_request);
                fail_count++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;
    int         cycles;
    bit         send_gaps;
    bit         recv_gaps;
    bit         hold_req;
    key_state_board board;

    kpa_in_if  button_ch ();
    kpa_out_if key_ch ();

    keypad_register_with_autofire u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .button_ch (button_ch),
        .key_ch    (key_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("keypad_register_with_autofire: mismatch");
        $finish;
    end

    // Key word receiver: random stalls, plus one long hold on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        key_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && key_ch.valid && key_ch.ready)
                board.check_word('{key_state: key_ch.key_state,
                                   shock_request: key_ch.shock_request});
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                key_ch.ready <= 1'b0;
            end
            else if (recv_gaps && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 8) - 1;
                key_ch.ready <= 1'b0;
            end
            else
                key_ch.ready <= 1'b1;
        end
    end

    // Offer one button word and hold it until taken
    task automatic send_word(logic mode, logic [3:0] button, logic pressed);
        kpa_item_t w;
        w.mode    = mode;
        w.button  = button;
        w.pressed = pressed;
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            button_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        button_ch.valid   <= 1'b1;
        button_ch.mode    <= w.mode;
        button_ch.button  <= w.button;
        button_ch.pressed <= w.pressed;
        do
            @(posedge clk);
        while (!button_ch.ready);
        board.note_word(w);
    endtask

    // Mostly mapped buttons, some unmapped codes; skip keeps one button held
    task automatic send_random(int n, int skip);
        logic [3:0] b;
        for (int k = 0; k < n; k++)
        begin
            do
            begin
                if ($urandom_range(0, 19) < 3)
                    b = 4'($urandom_range(9, 15));
                else
                    b = 4'($urandom_range(0, 8));
            end
            while (int'(b) == skip);
            send_word(1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
        end
    endtask

    // Stop offering and wait for every outstanding key word
    task automatic drain();
        button_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(int idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= 3'(idx);
        cfg_data  <= val;
        board.set_delay(idx, val);
    endtask

    task automatic cfg_done();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_delays(input logic [7:0] d [NUM_SLOTS]);
        for (int i = 0; i < NUM_SLOTS; i++)
            cfg_write(i, d[i]);
        cfg_done();
    endtask

    // Main sequence
    initial
    begin
        logic [7:0] d [NUM_SLOTS];
        board = new();
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        hold_req  = 1'b0;
        rst_n             <= 1'b0;
        button_ch.valid   <= 1'b0;
        button_ch.mode    <= MODE_KEYBOARD;
        button_ch.button  <= BTN_A;
        button_ch.pressed <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= 3'd0;
        cfg_data          <= 8'h00;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: keyboard direction memory on left/right
        send_word(MODE_KEYBOARD, BTN_LEFT, 1'b1);
        send_word(MODE_KEYBOARD, BTN_RIGHT, 1'b1);
        send_word(MODE_KEYBOARD, BTN_RIGHT, 1'b0);
        send_word(MODE_KEYBOARD, BTN_LEFT, 1'b0);
        // joystick up/down, no memory
        send_word(MODE_JOYSTICK, BTN_UP, 1'b1);
        send_word(MODE_JOYSTICK, BTN_DOWN, 1'b1);
        send_word(MODE_JOYSTICK, BTN_DOWN, 1'b0);
        // keyboard up/down memory
        send_word(MODE_KEYBOARD, BTN_UP, 1'b1);
        send_word(MODE_KEYBOARD, BTN_DOWN, 1'b1);
        send_word(MODE_KEYBOARD, BTN_DOWN, 1'b0);
        send_word(MODE_KEYBOARD, BTN_UP, 1'b0);
        // joystick left/right
        send_word(MODE_JOYSTICK, BTN_RIGHT, 1'b1);
        send_word(MODE_JOYSTICK, BTN_LEFT, 1'b1);
        send_word(MODE_JOYSTICK, BTN_LEFT, 1'b0);
        // plain buttons
        send_word(MODE_KEYBOARD, BTN_A, 1'b1);
        send_word(MODE_JOYSTICK, BTN_B, 1'b1);
        send_word(MODE_KEYBOARD, BTN_C, 1'b1);
        send_word(MODE_JOYSTICK, BTN_POWER, 1'b1);
        send_word(MODE_KEYBOARD, BTN_A, 1'b0);
        send_word(MODE_JOYSTICK, BTN_POWER, 1'b0);
        // shock press pulses, release does nothing
        send_word(MODE_KEYBOARD, BTN_SHOCK, 1'b1);
        send_word(MODE_JOYSTICK, BTN_SHOCK, 1'b0);
        // unmapped codes
        send_word(MODE_KEYBOARD, 4'd9, 1'b1);
        send_word(MODE_JOYSTICK, 4'd15, 1'b0);

        // No autofire, random words with idling on both sides
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        send_random(250, -1);
        drain();

        // Shortest autofire period on every slot
        foreach (d[i])
            d[i] = 8'd1;
        load_delays(d);
        send_random(200, -1);
        drain();

        // Mixed short periods, some slots off
        foreach (d[i])
            d[i] = 8'($urandom_range(0, 4));
        d[0] = 8'($urandom_range(1, 4));
        load_delays(d);
        send_random(250, -1);
        drain();

        // Long periods: A lowered while active, B runs its count to the top
        foreach (d[i])
            d[i] = 8'd0;
        d[BTN_A] = 8'd200;
        d[BTN_B] = 8'd255;
        load_delays(d);
        send_word(MODE_KEYBOARD, BTN_A, 1'b1);
        send_word(MODE_KEYBOARD, BTN_B, 1'b1);
        for (int k = 0; k < 10; k++)
            send_word(1'($urandom_range(0, 1)), 4'($urandom_range(9, 15)), 1'b1);
        drain();
        cfg_write(BTN_A, 8'd3);
        cfg_done();
        send_random(270, BTN_B);
        drain();

        // Small periods, last slot at the longest; receiver holds off long enough to stall the input
        foreach (d[i])
            d[i] = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 6)) : 8'd0;
        d[NUM_SLOTS - 1] = 8'd255;
        load_delays(d);
        hold_req = 1'b1;
        send_random(200, -1);
        drain();

        // Autofire off again, no idling to the end
        foreach (d[i])
            d[i] = 8'd0;
        load_delays(d);
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        send_random(150, -1);
        drain();

        if (board.fail_count == 0)
            $display("keypad_register_with_autofire: match");
        else
            $display("keypad_register_with_autofire: mismatch");
        $finish;
    end

endmodule
